FILE: hdl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scan driver package
// Shared constants, codes and types of the scan driver.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int SHIFT_COLUMNS = 256;
    localparam int SCAN_ROWS     = 16;
    localparam int PLANES        = 3;

    localparam int COL_W   = $clog2(SHIFT_COLUMNS);
    localparam int ROW_W   = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int ADDR_W  = 1 + ROW_W + COL_W;

    localparam int STORE_DEPTH = 2 * SCAN_ROWS * SHIFT_COLUMNS;
    localparam int CELL_W      = 6;
    localparam int WORD_W      = PLANES * CELL_W;

    localparam int LIGHT_W  = 14;
    localparam int GAP_W    = 16;
    localparam int TICK_W   = 16;
    localparam int SHIFT_W  = LIGHT_W + 8;
    localparam int TICK_MAX = (2 ** TICK_W) - 1;

    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 3;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 2;

    localparam logic [LIGHT_W-1:0] LIGHT_RESET = LIGHT_W'(150);
    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(1000);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SWAP  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic {
        REG_LIGHT_BASE = 1'b0,
        REG_FRAME_GAP  = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        PH_SHIFT_LOW  = 3'd0,
        PH_SHIFT_HIGH = 3'd1,
        PH_LATCH      = 3'd2,
        PH_LATCH_LOW  = 3'd3,
        PH_ROW_SELECT = 3'd4,
        PH_FRAME_GAP  = 3'd5
    } t_phase;

    // Cell bits: red, green, blue of the upper half, then of the lower half.
    typedef logic [CELL_W-1:0] t_cell;
    typedef t_cell [PLANES-1:0] t_word;

    typedef struct packed {
        logic       shift_clock;
        logic       latch;
        logic [3:0] row_address;
        logic       output_enable_n;
    } t_ctrl;

    typedef struct packed {
        t_cell data;
        t_ctrl ctrl;
    } t_pins;

    typedef struct packed {
        logic               load;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [COL_W-1:0]   col;
    } t_scan_rd;

    typedef struct packed {
        logic               wr;
        logic               swap;
        logic [ROW_W-1:0]   scan_row;
        logic [PLANE_W-1:0] scan_plane;
        logic [COL_W-1:0]   scan_col;
        logic [6:0]         px_col;
        logic [5:0]         px_row;
        logic [2:0]         red;
        logic [2:0]         green;
        logic [2:0]         blue;
    } t_fb_req;

endpackage

FILE: hdl/lmbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lmbs_frame_buf.sv
// ----------------------------------------------------------------------------
// Frame buffer
// Two-bank frame store with pixel read-modify-write, scan reads, bank swap
// and the clearing pass after reset.
// ----------------------------------------------------------------------------
module lmbs_frame_buf import lmbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_fb_req i_req,
    output logic    o_busy,
    output t_cell   o_cell
);

    logic               r_scan_bank;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_s1_wr;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_lower;
    logic [2:0]         r_s1_red;
    logic [2:0]         r_s1_green;
    logic [2:0]         r_s1_blue;
    logic [PLANE_W-1:0] r_s1_plane;
    logic               r_fwd;
    t_word              r_fwd_word;

    logic [4:0]         fold_row;
    logic [7:0]         fold_col;
    logic               in_range;
    logic [ROW_W-1:0]   px_row;
    logic [COL_W-1:0]   px_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_ok;
    logic               n_fwd;
    logic [WORD_W-1:0]  ram_rdata;
    t_word              old_word;
    t_word              new_word;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    always_comb begin
        if (!i_req.px_row[5]) begin
            fold_row = ~i_req.px_row[4:0];
            fold_col = {1'b0, ~i_req.px_col};
        end else begin
            fold_row = i_req.px_row[4:0];
            fold_col = {1'b1, i_req.px_col};
        end
    end

    assign in_range = (int'(fold_row[3:0]) < SCAN_ROWS) && (int'(fold_col) < SHIFT_COLUMNS);
    assign px_row   = ROW_W'(fold_row[3:0]);
    assign px_col   = COL_W'(fold_col);
    assign wr_ok    = i_req.wr && in_range;
    assign rd_addr  = i_req.wr ? {~r_scan_bank, px_row, px_col}
                               : {r_scan_bank, i_req.scan_row, i_req.scan_col};

    assign old_word = r_fwd ? r_fwd_word : t_word'(ram_rdata);

    always_comb begin
        logic [7:0] red8;
        logic [7:0] green8;
        logic [7:0] blue8;
        logic [2:0] bits3;
        red8   = {5'b0, r_s1_red};
        green8 = {5'b0, r_s1_green};
        blue8  = {5'b0, r_s1_blue};
        new_word = old_word;
        for (int p = 0; p < PLANES; p++) begin
            bits3 = {blue8[p], green8[p], red8[p]};
            if (r_s1_lower) begin
                new_word[p] = {bits3, old_word[p][2:0]};
            end else begin
                new_word[p] = {old_word[p][5:3], bits3};
            end
        end
    end

    assign n_fwd     = r_s1_wr && (rd_addr == r_s1_addr);
    assign ram_we    = r_clearing || r_s1_wr;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clearing ? '0 : WORD_W'(new_word);

    lmbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_bank <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_wr     <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (i_req.swap) begin
                r_scan_bank <= ~r_scan_bank;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_wr <= wr_ok;
            r_fwd   <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= rd_addr;
        r_s1_lower <= fold_row[4];
        r_s1_red   <= i_req.red;
        r_s1_green <= i_req.green;
        r_s1_blue  <= i_req.blue;
        r_s1_plane <= i_req.scan_plane;
        r_fwd_word <= new_word;
    end

    assign o_busy = r_clearing;
    assign o_cell = old_word[r_s1_plane];

    a_no_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_wr)
        else $error("Pixel write pending during the clearing pass.");

endmodule

FILE: hdl/lmbs_scan_seq.sv
// ----------------------------------------------------------------------------
// Scan sequencer
// Steps the column shift, latch, row select, lighting and frame gap timing.
// ----------------------------------------------------------------------------
module lmbs_scan_seq import lmbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [LIGHT_W-1:0] i_light_base,
    input  logic [GAP_W-1:0]   i_frame_gap,
    output t_scan_rd           o_rd,
    output t_ctrl              o_ctrl
);

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [COL_W-1:0]   r_col, n_col;
    logic [TICK_W-1:0]  r_light, n_light;
    logic [GAP_W-1:0]   r_gap, n_gap;
    t_ctrl              r_ctrl, n_ctrl;

    logic [TICK_W-1:0]  light_dec;
    logic [GAP_W-1:0]   gap_dec;
    logic               lit_done;
    logic               last_col;
    logic               last_plane;
    logic               last_row;
    logic [LIGHT_W-1:0] base_min;
    logic [SHIFT_W-1:0] shifted;
    logic [TICK_W-1:0]  period;

    assign light_dec  = (r_light != '0) ? r_light - 1'b1 : '0;
    assign lit_done   = (light_dec == '0);
    assign gap_dec    = (r_gap != '0) ? r_gap - 1'b1 : '0;
    assign last_col   = (r_col == COL_W'(SHIFT_COLUMNS - 1));
    assign last_plane = (r_plane == PLANE_W'(PLANES - 1));
    assign last_row   = (r_row == ROW_W'(SCAN_ROWS - 1));
    assign base_min   = (i_light_base == '0) ? LIGHT_W'(1) : i_light_base;
    assign shifted    = SHIFT_W'(base_min) << r_plane;
    assign period     = (shifted > SHIFT_W'(TICK_MAX)) ? '1 : TICK_W'(shifted);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SHIFT_LOW: begin
                n_phase = PH_SHIFT_HIGH;
            end
            PH_SHIFT_HIGH: begin
                n_phase = last_col ? PH_LATCH : PH_SHIFT_LOW;
            end
            PH_LATCH: begin
                if (lit_done) begin
                    n_phase = PH_LATCH_LOW;
                end
            end
            PH_LATCH_LOW: begin
                n_phase = PH_ROW_SELECT;
            end
            PH_ROW_SELECT: begin
                if (last_plane && last_row && (i_frame_gap != '0)) begin
                    n_phase = PH_FRAME_GAP;
                end else begin
                    n_phase = PH_SHIFT_LOW;
                end
            end
            PH_FRAME_GAP: begin
                if (gap_dec == '0) begin
                    n_phase = PH_SHIFT_LOW;
                end
            end
            default: begin
                n_phase = PH_SHIFT_LOW;
            end
        endcase
    end

    always_comb begin
        n_row   = r_row;
        n_plane = r_plane;
        n_col   = r_col;
        n_gap   = r_gap;
        n_light = light_dec;
        n_ctrl  = r_ctrl;
        if ((r_light != '0) && lit_done) begin
            n_ctrl.output_enable_n = 1'b1;
        end
        case (r_phase)
            PH_SHIFT_LOW: begin
                n_ctrl.shift_clock = 1'b0;
            end
            PH_SHIFT_HIGH: begin
                n_ctrl.shift_clock = 1'b1;
                n_col = last_col ? '0 : r_col + 1'b1;
            end
            PH_LATCH: begin
                if (lit_done) begin
                    n_ctrl.shift_clock = 1'b0;
                    n_ctrl.latch       = 1'b1;
                end
            end
            PH_LATCH_LOW: begin
                n_ctrl.latch = 1'b0;
            end
            PH_ROW_SELECT: begin
                n_ctrl.row_address     = 4'(r_row);
                n_ctrl.output_enable_n = 1'b0;
                n_light                = period;
                n_plane                = last_plane ? '0 : r_plane + 1'b1;
                if (last_plane) begin
                    n_row = last_row ? '0 : r_row + 1'b1;
                    if (last_row) begin
                        n_gap = i_frame_gap;
                    end
                end
            end
            PH_FRAME_GAP: begin
                n_gap = gap_dec;
            end
            default: begin
                n_ctrl = r_ctrl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SHIFT_LOW;
            r_row   <= '0;
            r_plane <= '0;
            r_col   <= '0;
            r_light <= '0;
            r_gap   <= '0;
            r_ctrl  <= '{shift_clock: 1'b0, latch: 1'b0, row_address: 4'd0,
                         output_enable_n: 1'b1};
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_plane <= n_plane;
            r_col   <= n_col;
            r_light <= n_light;
            r_gap   <= n_gap;
            r_ctrl  <= n_ctrl;
        end
    end

    assign o_rd.load  = (r_phase == PH_SHIFT_LOW);
    assign o_rd.row   = r_row;
    assign o_rd.plane = r_plane;
    assign o_rd.col   = r_col;
    assign o_ctrl     = n_ctrl;

    a_lit_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_light != '0) |-> !r_ctrl.output_enable_n)
        else $error("LEDs dark while the lighting count is still running.");

    a_latch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.latch == (r_phase == PH_LATCH_LOW))
        else $error("Latch strobe out of step with the scan phase.");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FRAME_GAP) |-> (r_gap != '0))
        else $error("Frame gap phase with an empty gap count.");

endmodule

FILE: hdl/lmbs_out_queue.sv
// ----------------------------------------------------------------------------
// Output queue
// Three-entry queue of pin results in front of the output channel.
// ----------------------------------------------------------------------------
module lmbs_out_queue import lmbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_pins             i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_pins             o_data,
    output logic [QCNT_W-1:0] o_count
);

    t_pins              r_entry [QDEPTH];
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |-> (r_count != QCNT_W'(QDEPTH)))
        else $error("Output queue overflow.");

endmodule

FILE: hdl/led_matrix_bitplane_scan_driver.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scan driver
// Double-buffered 1/16-scan RGB panel driver with three-plane binary code
// modulation.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid / o_stall) carries one operation per
// transaction: a pixel write into the draw bank, a bank swap, or one scan
// tick. Only a scan tick produces an output transaction (o_valid / i_stall),
// which carries the full panel pin state after that tick.
// Throughput is one transaction per cycle for any mix of operations while
// o_stall is low. A scan tick's result is registered after the frame store
// read and then pushed into the output queue. A pixel write is a
// read-modify-write of one frame store word that holds all planes of a
// column; back-to-back writes to the same word are forwarded.
// Results wait in a three-entry output queue; while the receiver stalls, the
// input channel stalls once the queue and the read stage hold three results.
// After reset the frame store is cleared, one word at a time, with o_stall high;
// configuration writes are taken at any time (o_cfg_ready stays high),
// register 0 is the plane-zero lighting time and register 1 the frame gap.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_scan_driver import lmbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_operation,
    input  logic [6:0]            i_pixel_column,
    input  logic [5:0]            i_pixel_row,
    input  logic [2:0]            i_red,
    input  logic [2:0]            i_green,
    input  logic [2:0]            i_blue,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_red_upper,
    output logic                  o_green_upper,
    output logic                  o_blue_upper,
    output logic                  o_red_lower,
    output logic                  o_green_lower,
    output logic                  o_blue_lower,
    output logic                  o_shift_clock,
    output logic                  o_latch,
    output logic [3:0]            o_row_address,
    output logic                  o_output_enable_n
);

    logic [LIGHT_W-1:0] r_light_base;
    logic [GAP_W-1:0]   r_frame_gap;
    logic               r_s1_tick;
    logic               r_s1_load;
    t_ctrl              r_s1_ctrl;
    t_cell              r_data;

    logic               accept;
    logic               is_tick;
    logic               fb_busy;
    t_cell              fb_cell;
    t_scan_rd           scan_rd;
    t_ctrl              scan_ctrl;
    t_fb_req            fb_req;
    t_cell              n_data;
    t_pins              push_data;
    t_pins              head;
    logic [QCNT_W-1:0]  q_count;
    logic [2:0]         pending;

    assign pending = 3'(q_count) + 3'(r_s1_tick);
    assign o_stall = fb_busy || (pending >= 3'(QDEPTH));
    assign accept  = i_valid && !o_stall;
    assign is_tick = accept && (i_operation == OP_TICK);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_base <= LIGHT_RESET;
            r_frame_gap  <= GAP_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_LIGHT_BASE: r_light_base <= i_cfg_data[LIGHT_W-1:0];
                REG_FRAME_GAP:  r_frame_gap  <= i_cfg_data[GAP_W-1:0];
                default:        r_frame_gap  <= r_frame_gap;
            endcase
        end
    end

    lmbs_scan_seq u_scan_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (is_tick),
        .i_light_base (r_light_base),
        .i_frame_gap  (r_frame_gap),
        .o_rd         (scan_rd),
        .o_ctrl       (scan_ctrl)
    );

    assign fb_req.wr         = accept && (i_operation == OP_WRITE);
    assign fb_req.swap       = accept && (i_operation == OP_SWAP);
    assign fb_req.scan_row   = scan_rd.row;
    assign fb_req.scan_plane = scan_rd.plane;
    assign fb_req.scan_col   = scan_rd.col;
    assign fb_req.px_col     = i_pixel_column;
    assign fb_req.px_row     = i_pixel_row;
    assign fb_req.red        = i_red;
    assign fb_req.green      = i_green;
    assign fb_req.blue       = i_blue;

    lmbs_frame_buf u_frame_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fb_req),
        .o_busy  (fb_busy),
        .o_cell  (fb_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tick <= 1'b0;
            r_s1_load <= 1'b0;
            r_data    <= '0;
        end else begin
            r_s1_tick <= is_tick;
            r_s1_load <= is_tick && scan_rd.load;
            if (r_s1_tick) begin
                r_data <= n_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctrl <= scan_ctrl;
    end

    assign n_data         = r_s1_load ? fb_cell : r_data;
    assign push_data.data = n_data;
    assign push_data.ctrl = r_s1_ctrl;

    lmbs_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_tick),
        .i_data  (push_data),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (head),
        .o_count (q_count)
    );

    assign o_red_upper       = head.data[0];
    assign o_green_upper     = head.data[1];
    assign o_blue_upper      = head.data[2];
    assign o_red_lower       = head.data[3];
    assign o_green_lower     = head.data[4];
    assign o_blue_lower      = head.data[5];
    assign o_shift_clock     = head.ctrl.shift_clock;
    assign o_latch           = head.ctrl.latch;
    assign o_row_address     = head.ctrl.row_address;
    assign o_output_enable_n = head.ctrl.output_enable_n;

    a_room_for_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= 3'(QDEPTH))
        else $error("More results in flight than the output queue can hold.");

    a_tick_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick |=> r_s1_tick)
        else $error("Accepted scan tick did not reach the result stage.");

endmodule

FILE: tb/sv/scan_pin_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan pin checker
// Watches the operation, configuration and pin channels of the scan driver.
// Keeps its own copy of both frame banks and of the scan sequencer, works out
// the panel pins that every accepted scan tick must produce, and compares each
// output transaction with the oldest pending prediction.
// ----------------------------------------------------------------------------
module scan_pin_check import lmbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [6:0]            i_pixel_column,
    input  logic [5:0]            i_pixel_row,
    input  logic [2:0]            i_red,
    input  logic [2:0]            i_green,
    input  logic [2:0]            i_blue,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_red_upper,
    input  logic                  i_green_upper,
    input  logic                  i_blue_upper,
    input  logic                  i_red_lower,
    input  logic                  i_green_lower,
    input  logic                  i_blue_lower,
    input  logic                  i_shift_clock,
    input  logic                  i_latch,
    input  logic [3:0]            i_row_address,
    input  logic                  i_output_enable_n,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       red_upper;
        logic       green_upper;
        logic       blue_upper;
        logic       red_lower;
        logic       green_lower;
        logic       blue_lower;
        logic       shift_clock;
        logic       latch;
        logic [3:0] row_address;
        logic       output_enable_n;
    } t_panel_pins;

    // Cell layout: [2:0] upper blue, green, red; [5:3] lower blue, green, red.
    logic [5:0]   frame_mem [0:1][0:SCAN_ROWS-1][0:PLANES-1][0:SHIFT_COLUMNS-1];

    logic         scan_bank;
    int unsigned  scan_row;
    int unsigned  scan_plane;
    int unsigned  scan_col;
    t_phase       phase;
    int unsigned  light_left;
    int unsigned  gap_left;
    logic [5:0]   pin_cell;
    logic         pin_clk;
    logic         pin_latch;
    logic [3:0]   pin_addr;
    logic         pin_oe_n;
    logic [LIGHT_W-1:0] light_base;
    logic [GAP_W-1:0]   gap_len;

    t_panel_pins  pins_due [$];
    int           mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic clear_model();
        for (int b = 0; b < 2; b++)
            for (int r = 0; r < SCAN_ROWS; r++)
                for (int p = 0; p < PLANES; p++)
                    for (int c = 0; c < SHIFT_COLUMNS; c++)
                        frame_mem[b][r][p][c] = '0;
        scan_bank  = 1'b0;
        scan_row   = 0;
        scan_plane = 0;
        scan_col   = 0;
        phase      = PH_SHIFT_LOW;
        light_left = 0;
        gap_left   = 0;
        pin_cell   = '0;
        pin_clk    = 1'b0;
        pin_latch  = 1'b0;
        pin_addr   = '0;
        pin_oe_n   = 1'b1;
        light_base = LIGHT_RESET;
        gap_len    = GAP_RESET;
        pins_due.delete();
    endtask

    task automatic paint_pixel(logic [6:0] col_in, logic [5:0] row_in,
                               logic [2:0] r, logic [2:0] g, logic [2:0] b);
        int   frow;
        int   fcol;
        logic lower;
        if (row_in < 32) begin
            frow = 31 - int'(row_in);
            fcol = 127 - int'(col_in);
        end else begin
            frow = int'(row_in) - 32;
            fcol = int'(col_in) + 128;
        end
        lower = (frow >= 16);
        if (lower)
            frow = frow - 16;
        if (frow < SCAN_ROWS && fcol < SHIFT_COLUMNS) begin
            for (int p = 0; p < PLANES; p++) begin
                if (lower)
                    frame_mem[~scan_bank][frow][p][fcol][5:3] = {b[p], g[p], r[p]};
                else
                    frame_mem[~scan_bank][frow][p][fcol][2:0] = {b[p], g[p], r[p]};
            end
        end
    endtask

    task automatic advance_scan(output t_panel_pins pins);
        int unsigned span;
        if (light_left != 0) begin
            light_left--;
            if (light_left == 0)
                pin_oe_n = 1'b1;
        end
        case (phase)
            PH_SHIFT_LOW: begin
                pin_cell = frame_mem[scan_bank][scan_row][scan_plane][scan_col];
                pin_clk  = 1'b0;
                phase    = PH_SHIFT_HIGH;
            end
            PH_SHIFT_HIGH: begin
                pin_clk = 1'b1;
                if (scan_col == SHIFT_COLUMNS - 1) begin
                    scan_col = 0;
                    phase    = PH_LATCH;
                end else begin
                    scan_col++;
                    phase = PH_SHIFT_LOW;
                end
            end
            PH_LATCH: begin
                if (light_left == 0) begin
                    pin_clk   = 1'b0;
                    pin_latch = 1'b1;
                    phase     = PH_LATCH_LOW;
                end
            end
            PH_LATCH_LOW: begin
                pin_latch = 1'b0;
                phase     = PH_ROW_SELECT;
            end
            PH_ROW_SELECT: begin
                span = (light_base == 0) ? 1 : int'(light_base);
                span = span << scan_plane;
                if (span > TICK_MAX)
                    span = TICK_MAX;
                pin_addr   = 4'(scan_row);
                pin_oe_n   = 1'b0;
                light_left = span;
                phase      = PH_SHIFT_LOW;
                if (scan_plane == PLANES - 1) begin
                    scan_plane = 0;
                    if (scan_row == SCAN_ROWS - 1) begin
                        scan_row = 0;
                        gap_left = gap_len;
                        if (gap_left != 0)
                            phase = PH_FRAME_GAP;
                    end else begin
                        scan_row++;
                    end
                end else begin
                    scan_plane++;
                end
            end
            PH_FRAME_GAP: begin
                if (gap_left != 0)
                    gap_left--;
                if (gap_left == 0)
                    phase = PH_SHIFT_LOW;
            end
            default: phase = PH_SHIFT_LOW;
        endcase
        pins = {pin_cell[0], pin_cell[1], pin_cell[2], pin_cell[3], pin_cell[4],
                pin_cell[5], pin_clk, pin_latch, pin_addr, pin_oe_n};
    endtask

    function automatic string pins_text(t_panel_pins p);
        return $sformatf("upper rgb=%b%b%b lower rgb=%b%b%b clk=%b latch=%b row=%0d oe_n=%b",
                         p.red_upper, p.green_upper, p.blue_upper, p.red_lower,
                         p.green_lower, p.blue_lower, p.shift_clock, p.latch,
                         p.row_address, p.output_enable_n);
    endfunction

    always @(posedge i_clk) begin
        t_panel_pins seen;
        t_panel_pins due;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_LIGHT_BASE: light_base = i_cfg_data[LIGHT_W-1:0];
                    REG_FRAME_GAP:  gap_len    = i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen = {i_red_upper, i_green_upper, i_blue_upper, i_red_lower,
                        i_green_lower, i_blue_lower, i_shift_clock, i_latch,
                        i_row_address, i_output_enable_n};
                if (pins_due.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected pin transaction: %s", $realtime,
                                 pins_text(seen));
                    mismatch_count++;
                end else begin
                    due = pins_due.pop_front();
                    if (seen !== due) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: pin mismatch: expected %s, actual %s", $realtime,
                                     pins_text(due), pins_text(seen));
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_operation)
                    OP_WRITE: paint_pixel(i_pixel_column, i_pixel_row, i_red, i_green, i_blue);
                    OP_SWAP:  scan_bank = ~scan_bank;
                    OP_TICK: begin
                        advance_scan(due);
                        pins_due.push_back(due);
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= pins_due.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan driver testbench
// Drives pixel writes, bank swaps and scan ticks into the LED matrix scan
// driver under random idle and stall, reprograms the lighting and frame gap
// registers between runs, and takes the verdict from the pin checker.
// ----------------------------------------------------------------------------
module tb;
    import lmbs_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         DRAIN_WAIT  = 8;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_valid           = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_operation       = OP_TICK;
    logic [6:0]            i_pixel_column    = '0;
    logic [5:0]            i_pixel_row       = '0;
    logic [2:0]            i_red             = '0;
    logic [2:0]            i_green           = '0;
    logic [2:0]            i_blue            = '0;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index       = REG_LIGHT_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  o_valid;
    logic                  i_stall           = 1'b0;
    logic                  o_red_upper;
    logic                  o_green_upper;
    logic                  o_blue_upper;
    logic                  o_red_lower;
    logic                  o_green_lower;
    logic                  o_blue_lower;
    logic                  o_shift_clock;
    logic                  o_latch;
    logic [3:0]            o_row_address;
    logic                  o_output_enable_n;

    logic                  calm              = 1'b0;
    int                    cycle_count       = 0;
    int                    mismatch_total;
    int                    results_pending;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    led_matrix_bitplane_scan_driver uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row       (i_pixel_row),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_red_upper       (o_red_upper),
        .o_green_upper     (o_green_upper),
        .o_blue_upper      (o_blue_upper),
        .o_red_lower       (o_red_lower),
        .o_green_lower     (o_green_lower),
        .o_blue_lower      (o_blue_lower),
        .o_shift_clock     (o_shift_clock),
        .o_latch           (o_latch),
        .o_row_address     (o_row_address),
        .o_output_enable_n (o_output_enable_n)
    );

    scan_pin_check u_pin_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_operation       (i_operation),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row       (i_pixel_row),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_red_upper       (o_red_upper),
        .i_green_upper     (o_green_upper),
        .i_blue_upper      (o_blue_upper),
        .i_red_lower       (o_red_lower),
        .i_green_lower     (o_green_lower),
        .i_blue_lower      (o_blue_lower),
        .i_shift_clock     (o_shift_clock),
        .i_latch           (o_latch),
        .i_row_address     (o_row_address),
        .i_output_enable_n (o_output_enable_n),
        .o_mismatches      (mismatch_total),
        .o_pending         (results_pending)
    );

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 24);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_op(logic [1:0] op, logic [6:0] col, logic [5:0] row,
                           logic [2:0] r, logic [2:0] g, logic [2:0] b);
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_pixel_column <= col;
        i_pixel_row    <= row;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(logic [1:0] op);
        send_op(op, 7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)));
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Each run writes random pixels into the draw bank, swaps it onto the panel and then scans,
    // with sparse writes, swaps and unused operations mixed into the ticks.
    task automatic run_scan(logic [CFG_DATA_W-1:0] light_word,
                            logic [CFG_DATA_W-1:0] gap_word, int unsigned tick_total);
        int unsigned ticks_done;
        int unsigned pick;
        wait_drained();
        write_reg(REG_LIGHT_BASE, light_word);
        write_reg(REG_FRAME_GAP, gap_word);
        repeat (8) send_random(OP_WRITE);
        send_random(OP_SWAP);
        ticks_done = 0;
        while (ticks_done < tick_total) begin
            pick = $urandom_range(0, 9999);
            if (pick < 20) begin
                send_random(OP_WRITE);
            end else if (pick < 22) begin
                send_random(OP_SWAP);
            end else if (pick < 24) begin
                send_random(OP_UNUSED);
            end else begin
                send_random(OP_TICK);
                ticks_done++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners of both halves, with back-to-back writes that share one store word.
        send_op(OP_WRITE, 7'd127, 6'd31, 3'd7, 3'd7, 3'd7);
        send_op(OP_WRITE, 7'd127, 6'd15, 3'd5, 3'd2, 3'd6);
        send_op(OP_WRITE, 7'd127, 6'd15, 3'd2, 3'd5, 3'd1);
        send_op(OP_WRITE, 7'd0, 6'd32, 3'd1, 3'd2, 3'd4);
        send_op(OP_WRITE, 7'd127, 6'd63, 3'd7, 3'd0, 3'd7);
        send_op(OP_WRITE, 7'd0, 6'd0, 3'd7, 3'd7, 3'd7);
        send_op(OP_WRITE, 7'd5, 6'd3, 3'd3, 3'd6, 3'd5);
        send_op(OP_WRITE, 7'd5, 6'd19, 3'd6, 3'd3, 3'd2);
        send_op(OP_WRITE, 7'd0, 6'd47, 3'd4, 3'd4, 3'd4);
        send_op(OP_WRITE, 7'd0, 6'd48, 3'd0, 3'd7, 3'd0);
        send_op(OP_UNUSED, 7'd127, 6'd63, 3'd7, 3'd7, 3'd7);
        send_op(OP_SWAP, 7'd0, 6'd0, 3'd0, 3'd0, 3'd0);
        repeat (8) send_random(OP_TICK);
        send_op(OP_SWAP, 7'd127, 6'd63, 3'd7, 3'd7, 3'd7);
        send_op(OP_WRITE, 7'd127, 6'd31, 3'd0, 3'd0, 3'd0);
        repeat (4) send_random(OP_TICK);

        run_scan(16'd1, 16'hFFFF, 120);
        run_scan(CFG_DATA_W'($urandom_range(1, 700)),
                 CFG_DATA_W'($urandom_range(0, 2000)), 120);
        calm <= 1'b1;
        run_scan(16'h3FFF, 16'hFFFF, 120);
        calm <= 1'b0;
        // The first latch and row select fall in this run, with a zero lighting
        // base given with the upper data bits set and no frame gap.
        run_scan(16'hC000, 16'd0, 150);

        wait_drained();
        if (mismatch_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
